FILE: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Operation codes, default sizes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned DefDepth      = 16;
  localparam int unsigned DefKeyWidth   = 32;
  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned CapWidth      = 5;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_STORE  = 2'd1,
    OP_DELETE = 2'd2,
    OP_EMPTY  = 2'd3
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request
    logic search;    // run one search step
    logic apply;     // commit the update, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
  } sts_t;

endpackage

FILE: hdl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer
// Steps each request through capture, search, update and result.
// ----------------------------------------------------------------------------
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.search = (state_q == S_SEARCH);
    cmd_o.apply  = (state_q == S_APPLY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) state_q <= S_SEARCH;
        end
        S_SEARCH: begin
          if (sts_i.search_done) state_q <= S_APPLY;
        end
        S_APPLY: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/lkvc_dp.sv
// ----------------------------------------------------------------------------
// lkvc_dp: cache datapath
// Entry tables, recency list, key search and result register.
// ----------------------------------------------------------------------------
module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int unsigned DEPTH       = DefDepth,
  parameter int unsigned KEY_WIDTH   = DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [CapWidth-1:0]    cap_i,
  input  logic [1:0]             op_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_in_i,
  output logic                   hit_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic                   evicted_o,
  output logic [KEY_WIDTH-1:0]   evicted_key_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SEG = 8;
  localparam int unsigned NSEG = (DEPTH + SEG - 1) / SEG;
  localparam int unsigned GW = (NSEG > 1) ? $clog2(NSEG) : 1;

  logic [KEY_WIDTH-1:0]   keys_q   [DEPTH];
  logic [VALUE_WIDTH-1:0] vals_q   [DEPTH];
  logic [IW-1:0]          fresh_q  [DEPTH];
  logic [IW-1:0]          stale_q  [DEPTH];
  logic                   fnone_q  [DEPTH];
  logic                   snone_q  [DEPTH];
  logic [DEPTH-1:0]       valid_q;
  logic [IW-1:0]          head_q, tail_q;
  logic                   empty_q;
  logic [CW-1:0]          used_q;

  logic [1:0]             op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [GW-1:0]          seg_q;
  logic                   found_q, free_found_q;
  logic [IW-1:0]          slot_q, free_q;

  logic                   rhit_q, rev_q;
  logic [VALUE_WIDTH-1:0] rval_q;
  logic [KEY_WIDTH-1:0]   rkey_q;

  // one segment of the search per cycle
  logic          seg_hit, seg_free;
  logic [IW-1:0] seg_hit_idx, seg_free_idx;
  always_comb begin
    logic [IW+GW:0] idx;
    seg_hit = 1'b0; seg_free = 1'b0;
    seg_hit_idx = '0; seg_free_idx = '0;
    for (int j = SEG - 1; j >= 0; j--) begin
      idx = (IW+GW+1)'(seg_q) * (IW+GW+1)'(SEG) + (IW+GW+1)'(j);
      if (idx < (IW+GW+1)'(DEPTH)) begin
        if (valid_q[idx[IW-1:0]] && keys_q[idx[IW-1:0]] == key_q) begin
          seg_hit = 1'b1; seg_hit_idx = idx[IW-1:0];
        end
        if (!valid_q[idx[IW-1:0]]) begin
          seg_free = 1'b1; seg_free_idx = idx[IW-1:0];
        end
      end
    end
  end

  assign sts_o.search_done = (seg_q == GW'(NSEG - 1));

  logic [CW-1:0] limit;
  always_comb begin
    if (cap_i == '0 || 32'(cap_i) > DEPTH) limit = CW'(DEPTH);
    else limit = CW'(cap_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; key_q <= key_i; val_q <= value_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0; found_q <= 1'b0; free_found_q <= 1'b0;
      slot_q <= '0; free_q <= '0;
    end else if (cmd_i.load) begin
      seg_q <= '0; found_q <= 1'b0; free_found_q <= 1'b0;
    end else if (cmd_i.search) begin
      if (!sts_o.search_done) seg_q <= seg_q + GW'(1);
      if (!found_q && seg_hit) begin
        found_q <= 1'b1; slot_q <= seg_hit_idx;
      end
      if (!free_found_q && seg_free) begin
        free_found_q <= 1'b1; free_q <= seg_free_idx;
      end
    end
  end

  // update: unlink s (optional), then push s to fresh end (optional)
  logic          do_unlink, do_push, evict, take_free;
  logic [IW-1:0] s;
  always_comb begin
    do_unlink = 1'b0; do_push = 1'b0; evict = 1'b0; take_free = 1'b0;
    s = slot_q;
    if (op_q != OP_EMPTY) begin
      if (found_q) begin
        do_unlink = 1'b1;
        do_push = (op_q == OP_FETCH) || (op_q == OP_STORE);
      end else if (op_q == OP_STORE) begin
        if (used_q >= limit && !empty_q) begin
          evict = 1'b1; s = tail_q; do_unlink = 1'b1; do_push = 1'b1;
        end else if (free_found_q) begin
          take_free = 1'b1; s = free_q; do_push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [IW-1:0] h, t;
    logic hn, tn;
    if (!rst_ni) begin
      valid_q <= '0; head_q <= '0; tail_q <= '0; empty_q <= 1'b1; used_q <= '0;
      rhit_q <= 1'b0; rev_q <= 1'b0; rval_q <= '0; rkey_q <= '0;
    end else if (cmd_i.apply) begin
      h = head_q; t = tail_q; hn = empty_q; tn = empty_q;
      rhit_q <= found_q && (op_q != OP_EMPTY);
      rval_q <= (found_q && op_q == OP_FETCH) ? vals_q[slot_q] : '0;
      rev_q  <= evict;
      rkey_q <= evict ? keys_q[tail_q] : '0;
      if (op_q == OP_EMPTY) begin
        valid_q <= '0; empty_q <= 1'b1; used_q <= '0;
      end else begin
        if (do_unlink) begin
          if (!fnone_q[s]) begin
            stale_q[fresh_q[s]] <= stale_q[s]; snone_q[fresh_q[s]] <= snone_q[s];
          end else begin
            h = stale_q[s]; hn = snone_q[s];
          end
          if (!snone_q[s]) begin
            fresh_q[stale_q[s]] <= fresh_q[s]; fnone_q[stale_q[s]] <= fnone_q[s];
          end else begin
            t = fresh_q[s]; tn = fnone_q[s];
          end
        end
        if (do_push) begin
          fnone_q[s] <= 1'b1;
          stale_q[s] <= h; snone_q[s] <= hn;
          if (!hn) begin
            fresh_q[h] <= s; fnone_q[h] <= 1'b0;
          end
          h = s; hn = 1'b0;
          if (tn) begin
            t = s; tn = 1'b0;
          end
        end
        head_q <= h; tail_q <= t; empty_q <= hn;
        if (op_q == OP_STORE && (found_q || evict || take_free)) vals_q[s] <= val_q;
        if (evict || take_free) keys_q[s] <= key_q;
        if (take_free) begin
          valid_q[s] <= 1'b1; used_q <= used_q + CW'(1);
        end
        if (found_q && op_q == OP_DELETE) begin
          valid_q[s] <= 1'b0;
          if (used_q != '0) used_q <= used_q - CW'(1);
        end
      end
    end
  end

  assign hit_o         = rhit_q;
  assign value_out_o   = rval_q;
  assign evicted_o     = rev_q;
  assign evicted_key_o = rkey_q;

endmodule

FILE: hdl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: LRU key/value cache
// Fetch, store, delete and empty-all requests against a small LRU table.
//
//   channel  signals                               direction
//   in       in_valid_i/in_ready_o, op/key/value   request in
//   out      out_valid_o/out_ready_i, hit..key     result out
//   cfg      cfg_we_i, cfg_wdata_i                 capacity limit write
//
// Each request passes through capture, a search step for each 8-entry search
// segment and an update step. Result sits in an output register; a new request
// is taken once the unit is idle and that register is free or being read.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int unsigned DEPTH       = DefDepth,
  parameter int unsigned KEY_WIDTH   = DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CapWidth-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic                   evicted_o,
  output logic [KEY_WIDTH-1:0]   evicted_key_o
);

  logic [CapWidth-1:0] cap_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= '0;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  lkvc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lkvc_dp #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cap_i(cap_q),
    .op_i, .key_i, .value_in_i, .hit_o, .value_out_o, .evicted_o, .evicted_key_o
  );

endmodule
